FILE: sv/otf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otf_pkg
// shared constants and types of the otsu threshold finder
// ----------------------------------------------------------------------------
package otf_pkg;

  localparam int COUNT_BITS  = 18;
  localparam int PIX_BITS    = 8;
  localparam int BINS        = 256;
  localparam int ADDR_BITS   = 8;
  localparam int N_BITS      = COUNT_BITS + PIX_BITS;
  localparam int S_BITS      = N_BITS + PIX_BITS;
  localparam int D_BITS      = N_BITS + S_BITS;
  localparam int NUM_BITS    = 2 * D_BITS;
  localparam int DEN_BITS    = 2 * N_BITS;
  localparam int CMP_BITS    = NUM_BITS + DEN_BITS;
  localparam int DIGIT_BITS  = 8;
  localparam int MUL_A_BITS  = NUM_BITS;
  localparam int MUL_B_BITS  = ((D_BITS + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;
  localparam int MUL_STEPS   = MUL_B_BITS / DIGIT_BITS;
  localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [ADDR_BITS-1:0]  ADDR_LAST = ADDR_BITS'(BINS - 1);
  localparam logic [ADDR_BITS-1:0]  LAST_CAND = ADDR_BITS'(BINS - 2);

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel;
    logic                last;
  } otf_item_t;

  typedef struct packed {
    logic                  start;
    logic [MUL_A_BITS-1:0] a;
    logic [MUL_B_BITS-1:0] b;
  } otf_mul_req_t;

endpackage
`default_nettype wire

FILE: sv/otsu_threshold_finder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otsu_threshold_finder_unit
// otsu threshold search over a 256 bin histogram of 8-bit pixels
// ----------------------------------------------------------------------------
// usage
//   s_axis carries pixels, one per request, tlast on the final pixel of an
//   image. m_axis carries one threshold per image, sent after that pixel.
//   pixels are taken at one per cycle, while the queue has room, into a four
//   entry queue; the histogram engine behind it updates one bin per cycle
//   while counting. after the frame end the engine sums all bins, then
//   walks candidate levels 0..254: a level with an empty class skips the
//   multiplier, any other level takes six passes through a shared
//   byte-serial multiplier (8 steps each). the search is followed by a
//   clear of all 256 histogram bins.
//   s_axis_tready_o stays low while the queue is full, which can happen
//   during search and clear, when no pixels leave the queue.
//   reset runs the same clear of all bins before the first pixel is counted.
//   the result waits in an output register when m_axis is stalled; the
//   next frame's pixels are still accepted and counted meanwhile.
// ----------------------------------------------------------------------------
module otsu_threshold_finder_unit
  import otf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // slave side: pixel stream
  input  wire logic       s_axis_tvalid_i,
  output      logic       s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] pixel
  input  wire logic       s_axis_tlast_i,   // last_pixel
  // master side: threshold results
  output      logic       m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output      logic [7:0] m_axis_tdata_o    // [7:0] threshold
);

  otf_item_t item;
  logic      item_valid, item_pop;

  // front: intake and queue
  otf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_pixel_i    (s_axis_tdata_i),
    .s_last_i     (s_axis_tlast_i),
    .s_ready_o    (s_axis_tready_o),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  // back: histogram, search and result register
  otf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item),
    .item_valid_i    (item_valid),
    .item_pop_o      (item_pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_threshold_o (m_axis_tdata_o),
    .out_ready_i     (m_axis_tready_i)
  );

endmodule
`default_nettype wire

FILE: sv/otf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otf_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module otf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: sv/otf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otf_mul
// iterative multiplier, one byte of the second operand per cycle
// ----------------------------------------------------------------------------
module otf_mul
  import otf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire otf_mul_req_t         req_i,
  output      logic                 done_o,
  output      logic [PROD_BITS-1:0] prod_o
);

  localparam int CNT_BITS = $clog2(MUL_STEPS + 1);

  logic [MUL_A_BITS-1:0]            a_q;
  logic [MUL_B_BITS-1:0]            b_q;
  logic [PROD_BITS-1:0]             acc_q, acc_d;
  logic [MUL_A_BITS+DIGIT_BITS-1:0] part;
  logic [CNT_BITS-1:0]              cnt_q;
  logic                             busy_q, done_q;

  // msb digit first, accumulator shifts up by one digit a step
  always_comb begin
    part  = a_q * b_q[MUL_B_BITS-1 -: DIGIT_BITS];
    acc_d = {acc_q[PROD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}}
          + {{(PROD_BITS-MUL_A_BITS-DIGIT_BITS){1'b0}}, part};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_BITS'(MUL_STEPS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= {b_q[MUL_B_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

FILE: sv/otf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otf_front
// pixel intake and short queue towards the histogram engine
// ----------------------------------------------------------------------------
module otf_front
  import otf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  input  wire logic [PIX_BITS-1:0] s_pixel_i,
  input  wire logic                s_last_i,
  output      logic                s_ready_o,
  output      otf_item_t           item_o,
  output      logic                item_valid_o,
  input  wire logic                item_pop_i
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  otf_item_t             queue_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PTR_BITS:0]     fill_q;
  logic                  push, pop;

  assign s_ready_o    = (fill_q != (PTR_BITS+1)'(QUEUE_DEPTH));
  assign item_valid_o = (fill_q != '0);
  assign push         = s_valid_i && s_ready_o;
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
      if (push && !pop) begin
        fill_q <= fill_q + (PTR_BITS+1)'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - (PTR_BITS+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= '{pixel: s_pixel_i, last: s_last_i};
    end
  end

endmodule
`default_nettype wire

FILE: sv/otf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otf_back
// histogram update, otsu search sequencer and result register
// ----------------------------------------------------------------------------
module otf_back
  import otf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire otf_item_t           item_i,
  input  wire logic                item_valid_i,
  output      logic                item_pop_o,
  output      logic                out_valid_o,
  output      logic [PIX_BITS-1:0] out_threshold_o,
  input  wire logic                out_ready_i
);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_RUN      = 3'd1;
  localparam logic [2:0] ST_SUM      = 3'd2;
  localparam logic [2:0] ST_SCAN_RD  = 3'd3;
  localparam logic [2:0] ST_SCAN_ACC = 3'd4;
  localparam logic [2:0] ST_MUL_GO   = 3'd5;
  localparam logic [2:0] ST_MUL_WAIT = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  localparam logic [2:0] OP_SN    = 3'd0;  // s0 * N
  localparam logic [2:0] OP_WN    = 3'd1;  // S * n0
  localparam logic [2:0] OP_DD    = 3'd2;  // D * D
  localparam logic [2:0] OP_NN    = 3'd3;  // n0 * n1
  localparam logic [2:0] OP_LEFT  = 3'd4;  // num * best_den
  localparam logic [2:0] OP_RIGHT = 3'd5;  // best_num * den

  logic [2:0]            st_q, op_q;
  logic [ADDR_BITS:0]    idx_q;
  logic                  va_q, la_q, wv_q, rv_q, ov_q;
  logic [ADDR_BITS-1:0]  pa_q, wa_q, rt_q, best_t_q, out_q;
  logic [COUNT_BITS-1:0] wd_q;
  logic [N_BITS-1:0]     tot_q, n0_q, n0_new, n1_new;
  logic [S_BITS-1:0]     wsum_q, s0_q, s0_new;
  logic [D_BITS-1:0]     pa_prod_q, d_q;
  logic [NUM_BITS-1:0]   num_q, best_num_q;
  logic [DEN_BITS-1:0]   den_q, best_den_q;
  logic [CMP_BITS-1:0]   left_q;

  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, rdata, cur_cnt, inc_cnt;
  logic [N_BITS-1:0]     weighted;
  logic                  pop, empty_class, last_cand, out_free;
  otf_mul_req_t          mul_req;
  logic                  mul_done;
  logic [PROD_BITS-1:0]  prod;
  logic [D_BITS-1:0]     prod_lo;

  otf_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  otf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  // stop taking pixels once the frame end is in flight
  assign pop        = (st_q == ST_RUN) && item_valid_i && !(va_q && la_q);
  assign item_pop_o = pop;
  assign out_free   = !ov_q || out_ready_i;

  always_comb begin
    // forward the count written in the previous cycle
    cur_cnt     = (wv_q && (wa_q == pa_q)) ? wd_q : rdata;
    inc_cnt     = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
    weighted    = (st_q == ST_SUM) ? rt_q * rdata : idx_q[ADDR_BITS-1:0] * rdata;
    n0_new      = n0_q + N_BITS'(rdata);
    s0_new      = s0_q + S_BITS'(weighted);
    n1_new      = tot_q - n0_new;
    empty_class = (n0_new == '0) || (n1_new == '0);
    last_cand   = (idx_q[ADDR_BITS-1:0] == LAST_CAND);
    prod_lo     = prod[D_BITS-1:0];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[ADDR_BITS-1:0];
    ram_wdata = '0;
    ram_raddr = idx_q[ADDR_BITS-1:0];
    if (st_q == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (st_q == ST_RUN) begin
      ram_we    = va_q;
      ram_waddr = pa_q;
      ram_wdata = inc_cnt;
      ram_raddr = item_i.pixel;
    end
  end

  always_comb begin
    mul_req.start = (st_q == ST_MUL_GO);
    unique case (op_q)
      OP_SN: begin
        mul_req.a = MUL_A_BITS'(s0_q);
        mul_req.b = MUL_B_BITS'(tot_q);
      end
      OP_WN: begin
        mul_req.a = MUL_A_BITS'(wsum_q);
        mul_req.b = MUL_B_BITS'(n0_q);
      end
      OP_DD: begin
        mul_req.a = MUL_A_BITS'(d_q);
        mul_req.b = MUL_B_BITS'(d_q);
      end
      OP_NN: begin
        mul_req.a = MUL_A_BITS'(n0_q);
        mul_req.b = MUL_B_BITS'(tot_q - n0_q);
      end
      OP_LEFT: begin
        mul_req.a = num_q;
        mul_req.b = MUL_B_BITS'(best_den_q);
      end
      default: begin
        mul_req.a = best_num_q;
        mul_req.b = MUL_B_BITS'(den_q);
      end
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_CLEAR;
      op_q  <= OP_SN;
      idx_q <= '0;
      va_q  <= 1'b0;
      wv_q  <= 1'b0;
      rv_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      va_q <= pop;
      wv_q <= va_q && (st_q == ST_RUN);
      rv_q <= (st_q == ST_SUM) && !idx_q[ADDR_BITS];
      if ((st_q == ST_DONE) && out_free) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (st_q)
        ST_CLEAR: begin
          if (idx_q[ADDR_BITS-1:0] == ADDR_LAST) begin
            st_q  <= ST_RUN;
            idx_q <= '0;
          end else begin
            idx_q <= idx_q + (ADDR_BITS+1)'(1);
          end
        end
        ST_RUN: begin
          if (va_q && la_q) begin
            st_q  <= ST_SUM;
            idx_q <= '0;
          end
        end
        ST_SUM: begin
          if (idx_q[ADDR_BITS]) begin
            st_q  <= ST_SCAN_RD;
            idx_q <= '0;
          end else begin
            idx_q <= idx_q + (ADDR_BITS+1)'(1);
          end
        end
        ST_SCAN_RD: st_q <= ST_SCAN_ACC;
        ST_SCAN_ACC: begin
          if (!empty_class) begin
            op_q <= OP_SN;
            st_q <= ST_MUL_GO;
          end else if (last_cand) begin
            st_q <= ST_DONE;
          end else begin
            idx_q <= idx_q + (ADDR_BITS+1)'(1);
            st_q  <= ST_SCAN_RD;
          end
        end
        ST_MUL_GO: st_q <= ST_MUL_WAIT;
        ST_MUL_WAIT: begin
          if (mul_done) begin
            if (op_q != OP_RIGHT) begin
              op_q <= op_q + 3'd1;
              st_q <= ST_MUL_GO;
            end else if (last_cand) begin
              st_q <= ST_DONE;
            end else begin
              idx_q <= idx_q + (ADDR_BITS+1)'(1);
              st_q  <= ST_SCAN_RD;
            end
          end
        end
        default: begin
          if (out_free) begin
            st_q  <= ST_CLEAR;
            idx_q <= '0;
          end
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (pop) begin
      pa_q <= item_i.pixel;
      la_q <= item_i.last;
    end
    if (va_q && (st_q == ST_RUN)) begin
      wa_q <= pa_q;
      wd_q <= inc_cnt;
    end
    if ((st_q == ST_RUN) && va_q && la_q) begin
      tot_q  <= '0;
      wsum_q <= '0;
    end
    if (st_q == ST_SUM) begin
      rt_q <= idx_q[ADDR_BITS-1:0];
      if (rv_q) begin
        tot_q  <= tot_q + N_BITS'(rdata);
        wsum_q <= wsum_q + S_BITS'(weighted);
      end
      if (idx_q[ADDR_BITS]) begin
        n0_q       <= '0;
        s0_q       <= '0;
        best_num_q <= '0;
        best_den_q <= DEN_BITS'(1);
        best_t_q   <= '0;
      end
    end
    if (st_q == ST_SCAN_ACC) begin
      n0_q <= n0_new;
      s0_q <= s0_new;
    end
    if ((st_q == ST_MUL_WAIT) && mul_done) begin
      unique case (op_q)
        OP_SN:   pa_prod_q <= prod_lo;
        OP_WN:   d_q <= (pa_prod_q >= prod_lo) ? pa_prod_q - prod_lo : prod_lo - pa_prod_q;
        OP_DD:   num_q <= prod[NUM_BITS-1:0];
        OP_NN:   den_q <= prod[DEN_BITS-1:0];
        OP_LEFT: left_q <= prod[CMP_BITS-1:0];
        default: begin
          if (left_q > prod[CMP_BITS-1:0]) begin
            best_num_q <= num_q;
            best_den_q <= den_q;
            best_t_q   <= idx_q[ADDR_BITS-1:0];
          end
        end
      endcase
    end
    if ((st_q == ST_DONE) && out_free) begin
      out_q <= best_t_q;
    end
  end

  assign out_valid_o     = ov_q;
  assign out_threshold_o = out_q;

endmodule
`default_nettype wire

FILE: tb/sv/otsu_threshold_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_threshold_checker
// watches both streams, builds the histogram alongside the block and checks
// every threshold against an exact wide-integer otsu search
// ----------------------------------------------------------------------------
module otsu_threshold_checker
  import otf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  input  wire logic       s_axis_tready_i,
  input  wire logic [7:0] s_axis_tdata_i,
  input  wire logic       s_axis_tlast_i,
  input  wire logic       m_axis_tvalid_i,
  input  wire logic       m_axis_tready_i,
  input  wire logic [7:0] m_axis_tdata_i,
  output int              fail_count_o,
  output int              pending_o
);

  logic [COUNT_BITS-1:0] pixel_hist [BINS];
  logic [7:0]            threshold_q [$];

  // exact search, no rounding: compare d^2/(n0*n1) by cross-multiplication
  function automatic logic [7:0] otsu_search();
    logic [255:0] total, wsum, n0, s0, n1, a, b, d, num, den, best_num, best_den;
    logic [7:0]   best_t;
    total = '0;
    wsum  = '0;
    n0    = '0;
    s0    = '0;
    best_num = '0;
    best_den = 256'd1;
    best_t   = '0;
    for (int t = 0; t < BINS; t++) begin
      total += pixel_hist[t];
      wsum  += 256'(t) * pixel_hist[t];
    end
    for (int t = 0; t < BINS - 1; t++) begin
      n0 += pixel_hist[t];
      s0 += 256'(t) * pixel_hist[t];
      n1 = total - n0;
      if (n0 == 0 || n1 == 0) continue;
      a = s0 * total;
      b = wsum * n0;
      d = (a >= b) ? a - b : b - a;
      num = d * d;
      den = n0 * n1;
      if (num * best_den > best_num * den) begin
        best_num = num;
        best_den = den;
        best_t   = 8'(t);
      end
    end
    return best_t;
  endfunction

  assign pending_o = threshold_q.size();

  initial begin
    fail_count_o = 0;
    foreach (pixel_hist[i]) pixel_hist[i] = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (pixel_hist[s_axis_tdata_i] != COUNT_MAX)
          pixel_hist[s_axis_tdata_i] = pixel_hist[s_axis_tdata_i] + 1'b1;
        if (s_axis_tlast_i) begin
          threshold_q = {threshold_q, otsu_search()};
          foreach (pixel_hist[i]) pixel_hist[i] = '0;
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (threshold_q.size() == 0) begin
          $error("unexpected threshold %0d", m_axis_tdata_i);
          fail_count_o++;
        end else begin
          logic [7:0] want;
          want = threshold_q.pop_front();
          if (m_axis_tdata_i !== want) begin
            $error("threshold: expected %0d, actual %0d", want, m_axis_tdata_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb_otsu_threshold_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_otsu_threshold_finder_unit
// drives images of pixels with random gaps and output stalls, a long output
// hold-off and many random frames; checker gives verdict
// ----------------------------------------------------------------------------
module tb_otsu_threshold_finder_unit;
  import otf_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       pix_valid;
  logic       pix_ready;
  logic [7:0] pix_data;
  logic       pix_last;
  logic       thr_valid;
  logic       thr_ready;
  logic [7:0] thr_data;
  int         fail_count;
  int         pending;
  bit         idle_on;
  int         hold_req;
  longint     cycles;

  otsu_threshold_finder_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (pix_valid),
    .s_axis_tready_o (pix_ready),
    .s_axis_tdata_i  (pix_data),
    .s_axis_tlast_i  (pix_last),
    .m_axis_tvalid_o (thr_valid),
    .m_axis_tready_i (thr_ready),
    .m_axis_tdata_o  (thr_data)
  );

  otsu_threshold_checker chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (pix_valid),
    .s_axis_tready_i (pix_ready),
    .s_axis_tdata_i  (pix_data),
    .s_axis_tlast_i  (pix_last),
    .m_axis_tvalid_i (thr_valid),
    .m_axis_tready_i (thr_ready),
    .m_axis_tdata_i  (thr_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous limit: ~80 frames of worst-case search plus the long hold-off
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 5_000_000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // result side: random stalls while idling is on, or a long hold-off when one is requested
  initial begin
    int hold_cnt;
    hold_cnt  = 0;
    thr_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        thr_ready <= 1'b0;
      end else begin
        thr_ready <= idle_on ? ($urandom_range(99) >= 37) : 1'b1;
      end
    end
  end

  // one pixel request, with random idle cycles before it when idling is on
  task automatic send_pixel(input logic [7:0] level, input logic is_last);
    while (idle_on && $urandom_range(99) < 37) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix_data  <= level;
    pix_last  <= is_last;
    do @(posedge clk); while (!pix_ready);
    @(negedge clk);
  endtask

  // one image of random content in one of several shapes
  task automatic send_image(input int n_pix);
    int         shape;
    logic [7:0] lo_lvl, hi_lvl, lvl;
    shape  = $urandom_range(4);
    lo_lvl = $urandom;
    hi_lvl = $urandom;
    for (int i = 0; i < n_pix; i++) begin
      case (shape)
        0: lvl = $urandom;
        1: lvl = ($urandom_range(1) ? hi_lvl : lo_lvl) + 8'($urandom_range(6)) - 8'd3;
        2: lvl = lo_lvl;
        3: lvl = $urandom_range(1) ? hi_lvl : lo_lvl;
        default: lvl = $urandom_range(1) ? 8'($urandom_range(3)) : 8'(252 + $urandom_range(3));
      endcase
      send_pixel(lvl, i == n_pix - 1);
    end
  endtask

  task automatic wait_drained();
    pix_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    idle_on   = 1'b1;
    hold_req  = 0;
    pix_valid = 1'b0;
    pix_data  = '0;
    pix_last  = 1'b0;
    rst_n     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single pixel: no candidate, threshold zero
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    // all pixels on one level
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd128, 1'b1);
    // extremes: 0 and 255, then 254 and 255
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd255, 1'b1);
    // symmetric three levels: tie, lowest threshold wins
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd20, 1'b0);
    send_pixel(8'd30, 1'b1);
    // bimodal image
    send_pixel(8'd40, 1'b0);
    send_pixel(8'd41, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd201, 1'b0);
    send_pixel(8'd202, 1'b1);
    // every bit of the pixel
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hAA, 1'b1);
    wait_drained();

    // long output hold-off while images go in: the input queue fills
    hold_req = 60000;
    send_image(30);
    send_image(30);
    send_image(10);
    wait_drained();

    // random images; one stretch without idling
    for (int f = 0; f < 66; f++) begin
      idle_on = !(f >= 20 && f < 30);
      send_image($urandom_range(4) == 0 ? $urandom_range(1, 4) : $urandom_range(10, 55));
    end

    wait_drained();
    repeat (300) @(negedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
